// ----- rtl/core/ipf_pkg.sv -----
// Shared types, control word layout, condition flags and character codes.
package ipf_pkg;

  localparam int PC_W = 4;

  typedef logic [PC_W-1:0] pc_t;

  // program step addresses
  localparam pc_t ST_IDLE  = 4'd0;
  localparam pc_t ST_OPEN  = 4'd1;
  localparam pc_t ST_GRP   = 4'd2;
  localparam pc_t ST_HEX   = 4'd3;
  localparam pc_t ST_CMP1  = 4'd4;
  localparam pc_t ST_CMP2  = 4'd5;
  localparam pc_t ST_CLOSE = 4'd6;
  localparam pc_t ST_OCT   = 4'd7;
  localparam pc_t ST_DOT   = 4'd8;
  localparam pc_t ST_PCOL  = 4'd9;
  localparam pc_t ST_PORT  = 4'd10;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_HEX_HI = 8'h57;  // 'a' - 10
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LBRK   = 8'h5b;
  localparam logic [7:0] CH_RBRK   = 8'h5d;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    E_NONE,
    E_LIT,
    E_COLON_Q,
    E_DEC,
    E_HEX
  } emit_t;

  typedef enum logic [1:0] {
    L_NONE,
    L_HOST_DEC,
    L_HOST_CLOSE,
    L_PORT
  } last_t;

  typedef enum logic [2:0] {
    O_NONE,
    O_LOAD_ITEM,
    O_LOAD_OCT,
    O_LOAD_HEX,
    O_SKIP,
    O_LOAD_PORT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_START,
    C_START_V6,
    C_DEC_MORE,
    C_HEX_MORE,
    C_GRP_DONE,
    C_AT_BEST,
    C_RUN_AT_END,
    C_OCT_DONE,
    C_OCT_DONE_NP,
    C_NO_PORT
  } cond_t;

  typedef struct packed {
    emit_t      emit;
    logic [7:0] lit;
    last_t      last;
    op_t        op;
    cond_t      c1;
    pc_t        t1;
    cond_t      c2;
    pc_t        t2;
    cond_t      c3;
    pc_t        t3;
    pc_t        tf;
  } ctrl_word_t;

  typedef struct packed {
    logic start;
    logic start_v6;
    logic dec_more;
    logic hex_more;
    logic grp_done;
    logic at_best;
    logic run_at_end;
    logic oct_done;
    logic no_port;
  } cond_vec_t;

endpackage

// ----- rtl/core/ipf_ucode_rom.sv -----
// Microcode table: one control word per program step.
module ipf_ucode_rom (
  input  ipf_pkg::pc_t       pc,
  output ipf_pkg::ctrl_word_t cw
);

  function automatic ipf_pkg::ctrl_word_t mk(
    input ipf_pkg::emit_t emit,
    input logic [7:0]     lit,
    input ipf_pkg::last_t last,
    input ipf_pkg::op_t   op,
    input ipf_pkg::cond_t c1,
    input ipf_pkg::pc_t   t1,
    input ipf_pkg::cond_t c2,
    input ipf_pkg::pc_t   t2,
    input ipf_pkg::cond_t c3,
    input ipf_pkg::pc_t   t3,
    input ipf_pkg::pc_t   tf
  );
    ipf_pkg::ctrl_word_t w;
    w.emit = emit;
    w.lit  = lit;
    w.last = last;
    w.op   = op;
    w.c1   = c1;
    w.t1   = t1;
    w.c2   = c2;
    w.t2   = t2;
    w.c3   = c3;
    w.t3   = t3;
    w.tf   = tf;
    return w;
  endfunction

  always_comb begin
    unique case (pc)
      ipf_pkg::ST_IDLE: cw = mk(ipf_pkg::E_NONE, ipf_pkg::CH_NUL, ipf_pkg::L_NONE,
          ipf_pkg::O_LOAD_ITEM,
          ipf_pkg::C_START_V6, ipf_pkg::ST_OPEN, ipf_pkg::C_START, ipf_pkg::ST_OCT,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::ST_IDLE);
      ipf_pkg::ST_OPEN: cw = mk(ipf_pkg::E_LIT, ipf_pkg::CH_LBRK, ipf_pkg::L_NONE,
          ipf_pkg::O_NONE,
          ipf_pkg::C_AT_BEST, ipf_pkg::ST_CMP1, ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::ST_GRP);
      ipf_pkg::ST_GRP: cw = mk(ipf_pkg::E_COLON_Q, ipf_pkg::CH_COLON, ipf_pkg::L_NONE,
          ipf_pkg::O_LOAD_HEX,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::ST_HEX);
      ipf_pkg::ST_HEX: cw = mk(ipf_pkg::E_HEX, ipf_pkg::CH_NUL, ipf_pkg::L_NONE,
          ipf_pkg::O_NONE,
          ipf_pkg::C_HEX_MORE, ipf_pkg::ST_HEX, ipf_pkg::C_GRP_DONE, ipf_pkg::ST_CLOSE,
          ipf_pkg::C_AT_BEST, ipf_pkg::ST_CMP1, ipf_pkg::ST_GRP);
      ipf_pkg::ST_CMP1: cw = mk(ipf_pkg::E_LIT, ipf_pkg::CH_COLON, ipf_pkg::L_NONE,
          ipf_pkg::O_NONE,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::ST_CMP2);
      ipf_pkg::ST_CMP2: cw = mk(ipf_pkg::E_LIT, ipf_pkg::CH_COLON, ipf_pkg::L_NONE,
          ipf_pkg::O_SKIP,
          ipf_pkg::C_RUN_AT_END, ipf_pkg::ST_CLOSE, ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::ST_GRP);
      ipf_pkg::ST_CLOSE: cw = mk(ipf_pkg::E_LIT, ipf_pkg::CH_RBRK, ipf_pkg::L_HOST_CLOSE,
          ipf_pkg::O_NONE,
          ipf_pkg::C_NO_PORT, ipf_pkg::ST_IDLE, ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::ST_PCOL);
      ipf_pkg::ST_OCT: cw = mk(ipf_pkg::E_DEC, ipf_pkg::CH_NUL, ipf_pkg::L_HOST_DEC,
          ipf_pkg::O_NONE,
          ipf_pkg::C_DEC_MORE, ipf_pkg::ST_OCT, ipf_pkg::C_OCT_DONE_NP, ipf_pkg::ST_IDLE,
          ipf_pkg::C_OCT_DONE, ipf_pkg::ST_PCOL, ipf_pkg::ST_DOT);
      ipf_pkg::ST_DOT: cw = mk(ipf_pkg::E_LIT, ipf_pkg::CH_DOT, ipf_pkg::L_NONE,
          ipf_pkg::O_LOAD_OCT,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::ST_OCT);
      ipf_pkg::ST_PCOL: cw = mk(ipf_pkg::E_LIT, ipf_pkg::CH_COLON, ipf_pkg::L_NONE,
          ipf_pkg::O_LOAD_PORT,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::ST_PORT);
      ipf_pkg::ST_PORT: cw = mk(ipf_pkg::E_DEC, ipf_pkg::CH_NUL, ipf_pkg::L_PORT,
          ipf_pkg::O_NONE,
          ipf_pkg::C_DEC_MORE, ipf_pkg::ST_PORT, ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::ST_IDLE);
      default: cw = mk(ipf_pkg::E_NONE, ipf_pkg::CH_NUL, ipf_pkg::L_NONE,
          ipf_pkg::O_NONE,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE,
          ipf_pkg::C_NEVER, ipf_pkg::ST_IDLE, ipf_pkg::ST_IDLE);
    endcase
  end

endmodule

// ----- rtl/core/ipf_datapath.sv -----
// Datapath: address and port holding, decimal and hex digit units, zero-run scan.
module ipf_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ipf_pkg::ctrl_word_t cw,
  input  logic                start,
  input  logic                is_ipv6,
  input  logic [63:0]         addr_high,
  input  logic [63:0]         addr_low,
  input  logic                with_port,
  input  logic [15:0]         port_number,
  output ipf_pkg::cond_vec_t  cv,
  output logic                strobe,
  output logic [7:0]          char_code,
  output logic                last
);

  // first longest run of zero groups: {start[2:0], length[3:0]}
  function automatic logic [6:0] zero_run(input logic [7:0] zmask);
    logic [2:0] rs;
    logic [3:0] rl;
    logic [2:0] bs;
    logic [3:0] bl;
    rs = '0;
    rl = '0;
    bs = '0;
    bl = '0;
    for (int i = 0; i < 8; i++) begin
      if (!zmask[i]) begin
        rl = '0;
      end else begin
        if (rl == 4'd0) rs = 3'(i);
        rl = rl + 4'd1;
        if (rl > bl) begin
          bl = rl;
          bs = rs;
        end
      end
    end
    return {bs, bl};
  endfunction

  function automatic logic [2:0] dec_top(input logic [15:0] v);
    if (v >= 16'd10000)     return 3'd4;
    else if (v >= 16'd1000) return 3'd3;
    else if (v >= 16'd100)  return 3'd2;
    else if (v >= 16'd10)   return 3'd1;
    else                    return 3'd0;
  endfunction

  function automatic logic [1:0] hex_top(input logic [15:0] v);
    if (v[15:12] != 4'h0)    return 2'd3;
    else if (v[11:8] != 4'h0) return 2'd2;
    else if (v[7:4] != 4'h0)  return 2'd1;
    else                      return 2'd0;
  endfunction

  // k times the place value of decimal position pos
  function automatic logic [16:0] dec_weight(input logic [2:0] pos, input int k);
    logic [16:0] w;
    case (pos)
      3'd0:    w = 17'(k);
      3'd1:    w = 17'(k * 10);
      3'd2:    w = 17'(k * 100);
      3'd3:    w = 17'(k * 1000);
      default: w = 17'(k * 10000);
    endcase
    return w;
  endfunction

  logic [7:0][15:0] addr_q;
  logic [7:0][7:0]  hi_bytes;
  logic             wp;
  logic [15:0]      port;
  logic [15:0]      dec_val;
  logic [2:0]       dec_pos;
  logic [2:0]       oct_cnt;
  logic [15:0]      hex_val;
  logic [1:0]       hex_pos;
  logic [3:0]       idx;
  logic             need_colon;
  logic [2:0]       best_start;
  logic [3:0]       best_len;
  logic             run_at_end;

  logic [7:0][15:0] in_grp;
  logic [7:0]       zmask;
  logic [6:0]       run;
  logic [7:0]       oct_byte;
  logic [15:0]      cur_grp;
  logic [3:0]       dec_digit;
  logic [16:0]      dec_sub;
  logic [16:0]      w;
  logic [15:0]      dec_rem;
  logic [3:0]       hex_digit;
  logic             emit_now;
  logic [7:0]       char_next;
  logic             last_now;

  assign hi_bytes = addr_q[7:4];
  assign in_grp   = {addr_high, addr_low};
  assign oct_byte = hi_bytes[{1'b1, ~oct_cnt[1:0]}];
  assign cur_grp  = addr_q[~idx[2:0]];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      zmask[i] = (in_grp[7-i] == 16'h0000);
    end
    run = zero_run(zmask);
  end

  // digit at the current position; the value stays below ten of that place
  always_comb begin
    dec_digit = '0;
    dec_sub   = '0;
    w         = '0;
    for (int k = 1; k < 10; k++) begin
      w = dec_weight(dec_pos, k);
      if ({1'b0, dec_val} >= w) begin
        dec_digit = 4'(k);
        dec_sub   = w;
      end
    end
    dec_rem = 16'({1'b0, dec_val} - dec_sub);
  end

  assign hex_digit = hex_val[{hex_pos, 2'b00} +: 4];

  always_comb begin
    cv.start      = start;
    cv.start_v6   = start & is_ipv6;
    cv.dec_more   = (dec_pos != 3'd0);
    cv.hex_more   = (hex_pos != 2'd0);
    cv.grp_done   = idx[3];
    cv.at_best    = (best_len != 4'd0) && (idx == {1'b0, best_start});
    cv.run_at_end = run_at_end;
    cv.oct_done   = (oct_cnt == 3'd4);
    cv.no_port    = ~wp;
  end

  always_comb begin
    emit_now  = 1'b0;
    char_next = cw.lit;
    case (cw.emit)
      ipf_pkg::E_LIT: begin
        emit_now = 1'b1;
      end
      ipf_pkg::E_COLON_Q: begin
        emit_now  = need_colon;
        char_next = ipf_pkg::CH_COLON;
      end
      ipf_pkg::E_DEC: begin
        emit_now  = 1'b1;
        char_next = ipf_pkg::CH_ZERO + {4'h0, dec_digit};
      end
      ipf_pkg::E_HEX: begin
        emit_now  = 1'b1;
        char_next = (hex_digit < 4'd10) ? ipf_pkg::CH_ZERO + {4'h0, hex_digit}
                                        : ipf_pkg::CH_HEX_HI + {4'h0, hex_digit};
      end
      default: begin
        emit_now = 1'b0;
      end
    endcase
    case (cw.last)
      ipf_pkg::L_HOST_DEC:   last_now = (dec_pos == 3'd0) && (oct_cnt == 3'd4) && !wp;
      ipf_pkg::L_HOST_CLOSE: last_now = !wp;
      ipf_pkg::L_PORT:       last_now = (dec_pos == 3'd0);
      default:               last_now = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit_now;
    end
    char_code <= char_next;
    last      <= last_now & emit_now;

    if (cw.emit == ipf_pkg::E_DEC) begin
      dec_val <= dec_rem;
      dec_pos <= dec_pos - 3'd1;
    end
    if (cw.emit == ipf_pkg::E_HEX) begin
      hex_pos <= hex_pos - 2'd1;
    end

    case (cw.op)
      ipf_pkg::O_LOAD_ITEM: begin
        if (start) begin
          addr_q     <= {addr_high, addr_low};
          wp         <= with_port;
          port       <= port_number;
          dec_val    <= {8'h00, addr_high[63:56]};
          dec_pos    <= dec_top({8'h00, addr_high[63:56]});
          oct_cnt    <= 3'd1;
          idx        <= '0;
          need_colon <= 1'b0;
          best_start <= run[6:4];
          best_len   <= run[3:0];
          run_at_end <= (({1'b0, run[6:4]} + run[3:0]) == 4'd8);
        end
      end
      ipf_pkg::O_LOAD_OCT: begin
        dec_val <= {8'h00, oct_byte};
        dec_pos <= dec_top({8'h00, oct_byte});
        oct_cnt <= oct_cnt + 3'd1;
      end
      ipf_pkg::O_LOAD_HEX: begin
        hex_val    <= cur_grp;
        hex_pos    <= hex_top(cur_grp);
        idx        <= idx + 4'd1;
        need_colon <= 1'b1;
      end
      ipf_pkg::O_SKIP: begin
        idx        <= idx + best_len;
        need_colon <= 1'b0;
      end
      ipf_pkg::O_LOAD_PORT: begin
        dec_val <= port;
        dec_pos <= dec_top(port);
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/ip_address_text_formatter_top.sv -----
// IP address text formatter: microcode sequencer with its ROM and datapath.
// The edge that takes the start beat loads the item and leaves idle; the first
// character is then registered onto strobe. An item of N characters (4 to 47) keeps busy
// high through the one-character-per-step program; IPv6 spends one step opening the
// first group and one after a compressed run. The receiver cannot stall.
// Reset returns the sequencer to idle with no strobe; no state spans items.
module ip_address_text_formatter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        is_ipv6,
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  input  logic        with_port,
  input  logic [15:0] port_number,
  output logic        strobe,
  output logic [7:0]  char_code,
  output logic        last
);

  ipf_pkg::pc_t        pc;
  ipf_pkg::pc_t        pc_next;
  ipf_pkg::ctrl_word_t cw;
  ipf_pkg::cond_vec_t  cv;

  function automatic logic cond_true(input ipf_pkg::cond_t c, input ipf_pkg::cond_vec_t v);
    logic r;
    unique case (c)
      ipf_pkg::C_START:       r = v.start;
      ipf_pkg::C_START_V6:    r = v.start_v6;
      ipf_pkg::C_DEC_MORE:    r = v.dec_more;
      ipf_pkg::C_HEX_MORE:    r = v.hex_more;
      ipf_pkg::C_GRP_DONE:    r = v.grp_done;
      ipf_pkg::C_AT_BEST:     r = v.at_best;
      ipf_pkg::C_RUN_AT_END:  r = v.run_at_end;
      ipf_pkg::C_OCT_DONE:    r = v.oct_done;
      ipf_pkg::C_OCT_DONE_NP: r = v.oct_done & v.no_port;
      ipf_pkg::C_NO_PORT:     r = v.no_port;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

  ipf_ucode_rom u_rom (
    .pc (pc),
    .cw (cw)
  );

  ipf_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cw          (cw),
    .start       (start),
    .is_ipv6     (is_ipv6),
    .addr_high   (addr_high),
    .addr_low    (addr_low),
    .with_port   (with_port),
    .port_number (port_number),
    .cv          (cv),
    .strobe      (strobe),
    .char_code   (char_code),
    .last        (last)
  );

  assign busy = (pc != ipf_pkg::ST_IDLE);

  // priority branch: first true condition wins, else fall to the default target
  always_comb begin
    if (cond_true(cw.c1, cv))      pc_next = cw.t1;
    else if (cond_true(cw.c2, cv)) pc_next = cw.t2;
    else if (cond_true(cw.c3, cv)) pc_next = cw.t3;
    else                           pc_next = cw.tf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ipf_pkg::ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- verif/ip_address_text_formatter_top_test.sv -----
// Testbench for the IP address text formatter: directed and random addresses, checked per character.
module ip_address_text_formatter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit          v6;
    logic [63:0] hi;
    logic [63:0] lo;
    bit          wp;
    logic [15:0] port;
  } addr_item_t;

  typedef struct {
    logic [7:0] code;
    logic       fin;
  } text_char_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        is_ipv6 = 1'b0;
  logic [63:0] addr_high = '0;
  logic [63:0] addr_low = '0;
  logic        with_port = 1'b0;
  logic [15:0] port_number = '0;
  logic        strobe;
  logic [7:0]  char_code;
  logic        last;

  text_char_t  pending_chars[$];
  logic [7:0]  formatted_text[$];
  int          fail_count = 0;
  int          sender_idle_pct = 0;

  ip_address_text_formatter_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .is_ipv6     (is_ipv6),
    .addr_high   (addr_high),
    .addr_low    (addr_low),
    .with_port   (with_port),
    .port_number (port_number),
    .strobe      (strobe),
    .char_code   (char_code),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void append_decimal(input logic [15:0] value);
    logic [7:0]  digits[$];
    logic [15:0] rest;
    rest = value;
    do begin
      digits.push_front(ipf_pkg::CH_ZERO + 8'(rest % 16'd10));
      rest = rest / 16'd10;
    end while (rest != 0);
    foreach (digits[i]) formatted_text.push_back(digits[i]);
  endfunction

  function automatic void append_hex_group(input logic [15:0] grp);
    logic [3:0] nib;
    bit         leading;
    int         j;
    leading = 1'b1;
    for (j = 3; j >= 0; j--) begin
      nib = grp[j*4 +: 4];
      if (nib != 0 || j == 0) leading = 1'b0;
      if (!leading)
        formatted_text.push_back(nib < 4'd10 ? ipf_pkg::CH_ZERO + {4'h0, nib}
                                             : ipf_pkg::CH_HEX_HI + {4'h0, nib});
    end
  endfunction

  // Build the text of one address into formatted_text.
  function automatic void format_address_text(input addr_item_t it);
    logic [15:0] grp[8];
    int          g;
    int          run_len;
    int          best_start;
    int          best_len;
    bit          need_colon;
    formatted_text.delete();
    if (!it.v6) begin
      for (g = 0; g < 4; g++) begin
        if (g > 0) formatted_text.push_back(ipf_pkg::CH_DOT);
        append_decimal({8'h00, it.hi[63-8*g -: 8]});
      end
    end else begin
      for (g = 0; g < 8; g++)
        grp[g] = (g < 4) ? it.hi[63-16*g -: 16] : it.lo[63-16*(g-4) -: 16];
      run_len = 0;
      best_start = -1;
      best_len = 0;
      // strictly longer wins, so the leftmost of equal runs is kept
      for (g = 0; g < 8; g++) begin
        if (grp[g] != 0) begin
          run_len = 0;
        end else begin
          run_len++;
          if (run_len > best_len) begin
            best_len = run_len;
            best_start = g - run_len + 1;
          end
        end
      end
      formatted_text.push_back(ipf_pkg::CH_LBRK);
      need_colon = 1'b0;
      g = 0;
      while (g < 8) begin
        if (g == best_start) begin
          formatted_text.push_back(ipf_pkg::CH_COLON);
          formatted_text.push_back(ipf_pkg::CH_COLON);
          need_colon = 1'b0;
          g += best_len;
        end else begin
          if (need_colon) formatted_text.push_back(ipf_pkg::CH_COLON);
          need_colon = 1'b1;
          append_hex_group(grp[g]);
          g++;
        end
      end
      formatted_text.push_back(ipf_pkg::CH_RBRK);
    end
    if (it.wp) begin
      formatted_text.push_back(ipf_pkg::CH_COLON);
      append_decimal(it.port);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && strobe) begin
      if (pending_chars.size() == 0) begin
        $error("char_code: no character pending, actual %h", char_code);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (char_code !== want.code) begin
          $error("char_code: expected %h, actual %h", want.code, char_code);
          fail_count++;
        end
        if (last !== want.fin) begin
          $error("last: expected %b, actual %b", want.fin, last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- driving

  function automatic int idle_gap();
    int gap;
    gap = 0;
    if (sender_idle_pct == 0) return 0;
    // now and then a long pause before the next start beat
    if ($urandom_range(99) < sender_idle_pct / 4) return $urandom_range(50, 1);
    while ($urandom_range(99) < sender_idle_pct && gap < 20) gap++;
    return gap;
  endfunction

  // Hold start and the fields until the beat is taken, then queue the text.
  task automatic send_address(input addr_item_t it);
    int gap;
    int k;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    is_ipv6     <= it.v6;
    addr_high   <= it.hi;
    addr_low    <= it.lo;
    with_port   <= it.wp;
    port_number <= it.port;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    format_address_text(it);
    for (k = 0; k < formatted_text.size(); k++)
      pending_chars.push_back('{code: formatted_text[k], fin: (k == formatted_text.size() - 1)});
  endtask

  task automatic wait_text_drained();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  function automatic addr_item_t mk_item(input bit v6, input logic [63:0] hi,
                                         input logic [63:0] lo, input bit wp,
                                         input logic [15:0] port);
    addr_item_t it;
    it.v6 = v6;
    it.hi = hi;
    it.lo = lo;
    it.wp = wp;
    it.port = port;
    return it;
  endfunction

  function automatic logic [7:0] rand_octet();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(9, 1));
      3: return 8'($urandom_range(99, 10));
      4: return 8'($urandom_range(255, 100));
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] rand_group();
    case ($urandom_range(9))
      0, 1, 2, 3: return 16'h0000;
      4: return 16'($urandom_range(15, 1));
      5: return 16'($urandom_range(255, 16));
      6: return 16'($urandom_range(4095, 256));
      7: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] rand_port();
    case ($urandom_range(6))
      0: return 16'd0;
      1: return 16'd65535;
      2: return 16'($urandom_range(9, 1));
      3: return 16'($urandom_range(999, 10));
      4: return 16'($urandom_range(9999, 1000));
      default: return 16'($urandom_range(65535, 10000));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_ipv4_directed();
    send_address(mk_item(1'b0, 64'h00000000_00000000, 64'h0, 1'b0, 16'd0));
    // bits below the four octets and all of addr_low are dropped
    send_address(mk_item(1'b0, 64'hffffffff_ffffffff, 64'hffffffff_ffffffff, 1'b1,
                         16'd65535));
    send_address(mk_item(1'b0, 64'h01176409_deadbeef, 64'h12345678_9abcdef0, 1'b1, 16'd0));
    send_address(mk_item(1'b0, 64'h0a000001_00000000, 64'h0, 1'b1, 16'd8080));
    send_address(mk_item(1'b0, 64'hc0a863fa_5555aaaa, 64'haaaa5555_aaaa5555, 1'b0, 16'd443));
  endtask

  task automatic test_ipv6_directed();
    send_address(mk_item(1'b1, 64'h0, 64'h0, 1'b0, 16'd0));
    send_address(mk_item(1'b1, 64'h0, 64'h0, 1'b1, 16'd7));
    // longest possible text
    send_address(mk_item(1'b1, 64'hffffffff_ffffffff, 64'hffffffff_ffffffff, 1'b1,
                         16'd65535));
    send_address(mk_item(1'b1, 64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008, 1'b0,
                         16'd0));
    send_address(mk_item(1'b1, 64'h0001_0000_0003_0004, 64'h0005_0006_0007_0008, 1'b0,
                         16'd0));
    send_address(mk_item(1'b1, 64'h0001_0000_0000_0004, 64'h0005_0000_0000_0008, 1'b1,
                         16'd80));
    send_address(mk_item(1'b1, 64'h0001_0000_0005_0000, 64'h0000_0000_0007_0008, 1'b0,
                         16'd0));
    send_address(mk_item(1'b1, 64'h0000_0000_0000_0001, 64'h0002_0003_0004_0005, 1'b0,
                         16'd0));
    send_address(mk_item(1'b1, 64'h0001_0002_0003_0004, 64'h0005_0000_0000_0000, 1'b1,
                         16'd12345));
    send_address(mk_item(1'b1, 64'h0, 64'h0000_0000_0000_0001, 1'b0, 16'd0));
    send_address(mk_item(1'b1, 64'h0001_0000_0000_0000, 64'h0, 1'b0, 16'd0));
    send_address(mk_item(1'b1, 64'h000a_00bc_0def_1234, 64'hfedc_0ba9_0087_0006, 1'b1,
                         16'd999));
    send_address(mk_item(1'b1, 64'h0000_0001_0002_0003, 64'h0004_0005_0006_0007, 1'b0,
                         16'd0));
    send_address(mk_item(1'b1, 64'h0001_0002_0003_0004, 64'h0005_0006_0007_0000, 1'b1,
                         16'd1));
  endtask

  task automatic test_random_addresses(input int count, input int idle_pct);
    addr_item_t it;
    logic [15:0] grp[8];
    int          n;
    int          g;
    int          run_at;
    int          run_span;
    sender_idle_pct = idle_pct;
    for (n = 0; n < count; n++) begin
      it.v6 = 1'($urandom_range(1));
      it.wp = 1'($urandom_range(1));
      it.port = rand_port();
      if (!it.v6) begin
        it.hi = {rand_octet(), rand_octet(), rand_octet(), rand_octet(), 32'($urandom())};
        it.lo = {32'($urandom()), 32'($urandom())};
      end else if ($urandom_range(9) == 0) begin
        it.hi = {32'($urandom()), 32'($urandom())};
        it.lo = {32'($urandom()), 32'($urandom())};
      end else begin
        for (g = 0; g < 8; g++) grp[g] = rand_group();
        // force a long zero run now and then
        if ($urandom_range(3) == 0) begin
          run_at = $urandom_range(7);
          run_span = $urandom_range(8 - run_at, 1);
          for (g = run_at; g < run_at + run_span; g++) grp[g] = 16'h0000;
        end
        it.hi = {grp[0], grp[1], grp[2], grp[3]};
        it.lo = {grp[4], grp[5], grp[6], grp[7]};
      end
      send_address(it);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ipv4_directed();
    test_ipv6_directed();
    wait_text_drained();
    test_random_addresses(160, 28);
    wait_text_drained();
    test_random_addresses(160, 48);
    wait_text_drained();
    test_random_addresses(160, 0);
    wait_text_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
